>>> design/mxp_pkg.sv
// shared constants and types for the modular exponentiation core
package mxp_pkg;

    localparam int DATA_W            = 32;
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int PADDR_W           = 3;

    // register word select, taken from paddr[2]
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    localparam logic [DATA_W-1:0] MODULUS_RST  = DATA_W'(1);
    localparam logic [DATA_W-1:0] EXPONENT_RST = '0;

    // status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mxp_mul_status_t;

endpackage

>>> design/mxp_base_if.sv
// request channel carrying one base value
interface mxp_base_if
    import mxp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] base_value;

    modport source (output valid, output base_value, input ready);
    modport sink (input valid, input base_value, output ready);
endinterface

>>> design/mxp_result_if.sv
// request channel carrying one power result
interface mxp_result_if
    import mxp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink (input valid, input power_result, output ready);
endinterface

>>> design/mxp_modmul.sv
// bit-serial interleaved modular multiplier, one bit of op_a per cycle
module mxp_modmul
    import mxp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] op_a,
    input  logic [OPERAND_WIDTH-1:0] op_b,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    output mxp_mul_status_t          status,
    output logic [OPERAND_WIDTH-1:0] result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;
    logic [W-1:0]  r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [W+1:0]  sum;
    logic [W+2:0]  diff1;
    logic [W+2:0]  diff2;
    logic [W-1:0]  step_r;

    // r < m and b < m keep 2r + b below 3m: at most two subtractions
    always_comb
    begin
        sum    = {1'b0, r_reg, 1'b0} + {2'b00, (a_reg[W-1] ? b_reg : {W{1'b0}})};
        diff1  = {1'b0, sum} - {3'b000, m_reg};
        diff2  = {1'b0, sum} - {2'b00, m_reg, 1'b0};
        if (!diff2[W+2])
        begin
            step_r = diff2[W-1:0];
        end
        else if (!diff1[W+2])
        begin
            step_r = diff1[W-1:0];
        end
        else
        begin
            step_r = sum[W-1:0];
        end
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = op_a;
            b_next    = op_b;
            m_next    = modulus;
            r_next    = '0;
            cnt_next  = CW'(W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            a_next   = {a_reg[W-2:0], 1'b0};
            r_next   = step_r;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = r_reg;

endmodule

>>> design/modular_exponentiation_core.sv
// modular exponentiation core: right-to-left square-and-multiply over a shared multiplier
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+---------------------------------
//  in_ch    | in  | valid / ready         | base_value   [31:0]
//  out_ch   | out | valid / ready         | power_result [31:0]
//  apb      | in  | psel/penable/pwrite   | paddr[2:0], pwdata/prdata[31:0]
//
// a request first reduces the base mod m with one product, then runs through all
// W = OPERAND_WIDTH exponent bits on the bit-serial modular multiplier: a set bit
// takes one multiply and one square, a clear bit only the square.
// a modulus of 0 or 1 skips the multiplier and goes straight to the result write.
// reset clears the sequencer, the output valid and the registers
// (modulus 1, exponent 0); no clearing pass is needed.
// in_ch.ready is high only while the sequencer is idle; a finished result
// sits in the output register, so a new request is taken while it waits.
module modular_exponentiation_core
    import mxp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // request channels
    mxp_base_if.sink            in_ch,
    mxp_result_if.source        out_ch
);

    localparam int W  = OPERAND_WIDTH;
    localparam int BW = $clog2(W + 1);
    localparam int IW = $clog2(W);

    // one-hot sequencer states
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_NEXT   = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_SQR    = 6'b010000,
        ST_WRITE  = 6'b100000
    } mxp_state_t;

    mxp_state_t         state_reg, state_next;

    logic [DATA_W-1:0]  modulus_reg;
    logic [DATA_W-1:0]  exponent_reg;

    logic [W-1:0]       acc_reg, acc_next;
    logic [W-1:0]       base_reg, base_next;
    logic [BW-1:0]      bit_idx_reg, bit_idx_next;
    logic [DATA_W-1:0]  power_result_reg;
    logic               out_valid_reg, out_valid_next;

    logic [W-1:0]       mod_w;
    logic [W-1:0]       exp_w;
    logic               small_mod;
    logic               in_take;
    logic               out_load;
    logic               cfg_write;

    logic               mul_start;
    logic [W-1:0]       mul_a;
    logic [W-1:0]       mul_b;
    logic [W-1:0]       mul_result;
    mxp_mul_status_t    mul_status;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MODULUS_RST;
            exponent_reg <= EXPONENT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MODULUS:  modulus_reg  <= pwdata;
                REG_EXPONENT: exponent_reg <= pwdata;
                default:      modulus_reg  <= modulus_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MODULUS:  prdata = modulus_reg;
            REG_EXPONENT: prdata = exponent_reg;
            default:      prdata = '0;
        endcase
    end

    // only the low operand bits take part
    assign mod_w     = modulus_reg[W-1:0];
    assign exp_w     = exponent_reg[W-1:0];
    // modulus 0 or 1 reduces everything to 0; exponent 0 still gives 1
    assign small_mod = (mod_w <= W'(1));

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;
    // result register frees up in the same cycle it is taken
    assign out_load    = (state_reg == ST_WRITE) && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.power_result = power_result_reg;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        bit_idx_next = bit_idx_reg;
        mul_start    = 1'b0;
        mul_a        = base_reg;
        mul_b        = base_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                mul_a = in_ch.base_value[W-1:0];
                mul_b = W'(1);
                if (in_take)
                begin
                    bit_idx_next = '0;
                    if (small_mod)
                    begin
                        acc_next   = (exp_w == '0) ? W'(1) : '0;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        // base mod m computed as base * 1 mod m
                        acc_next   = W'(1);
                        mul_start  = 1'b1;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mul_status.done)
                begin
                    base_next  = mul_result;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (bit_idx_reg == BW'(W))
                begin
                    state_next = ST_WRITE;
                end
                else if (exp_w[bit_idx_reg[IW-1:0]])
                begin
                    mul_a      = acc_reg;
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (mul_status.done)
                begin
                    acc_next   = mul_result;
                    mul_start  = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mul_status.done)
                begin
                    base_next    = mul_result;
                    bit_idx_next = bit_idx_reg + 1'b1;
                    state_next   = ST_NEXT;
                end
            end
            ST_WRITE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_idx_reg   <= bit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        base_reg <= base_next;
        if (out_load)
        begin
            power_result_reg <= DATA_W'(acc_reg);
        end
    end

    // ------------------------------------------------------------------
    // shared modular multiplier
    // ------------------------------------------------------------------
    mxp_modmul #(
        .OPERAND_WIDTH (W)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (mod_w),
        .status  (mul_status),
        .result  (mul_result)
    );

`ifndef SYNTHESIS
    // the multiplier is never restarted while a product is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_status.busy)
        else $error("multiplier started while busy");

    // a finished product only arrives while the sequencer waits for one
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_status.done |->
            (state_reg == ST_REDUCE || state_reg == ST_MUL || state_reg == ST_SQR))
        else $error("multiplier done outside a product state");

    // exponent zero always yields one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && exp_w == '0) |=> power_result_reg == DATA_W'(1))
        else $error("exponent zero did not give one");

    // with a real modulus the result is fully reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !small_mod) |=> power_result_reg < DATA_W'(mod_w))
        else $error("result not reduced below modulus");
`endif

endmodule

>>> verif/tb_top.sv
// testbench for modular_exponentiation_core: predicts every power result and checks it in order
module tb_top
    import mxp_pkg::*;
();

    localparam int W             = OPERAND_WIDTH_DEF;
    // a quiet stretch longer than this, far beyond one full request, means a hang
    localparam int WATCHDOG_MAX  = 20000;
    // long enough for the core to finish one request, take the next and stall its input
    localparam int HOLD_CYCLES   = 8000;
    // after the last result, wait about one request time for anything stray
    localparam int SETTLE_CYCLES = 2300;
    localparam int ITEMS_PER_CFG = 10;
    localparam int CFGS_PER_PHASE = 6;

    localparam logic [PADDR_W-1:0] ADDR_MODULUS  = {REG_MODULUS, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_EXPONENT = {REG_EXPONENT, 2'b00};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    mxp_base_if   base_ch ();
    mxp_result_if result_ch ();

    // bench copy of the two registers, used to predict each request
    logic [DATA_W-1:0] modulus_shadow;
    logic [DATA_W-1:0] exponent_shadow;

    // predicted power results, oldest first
    logic [DATA_W-1:0] pending_powers[$];

    int mismatch_cnt = 0;
    int quiet_cycles = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // nonzero asks the receiver to hold ready low for that many cycles
    int rx_hold_req  = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    modular_exponentiation_core #(
        .OPERAND_WIDTH (W)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (base_ch),
        .out_ch  (result_ch)
    );

    // ------------------------------------------------------------------
    // power predictor
    // ------------------------------------------------------------------

    // reduction by a zero modulus gives zero
    function automatic logic [63:0] mod_reduce(input logic [63:0] x, input logic [63:0] m);
        if (m == 64'd0)
            return 64'd0;
        return x % m;
    endfunction

    // right-to-left square-and-multiply over all W exponent bits
    function automatic logic [DATA_W-1:0] expected_power(input logic [DATA_W-1:0] base,
                                                         input logic [DATA_W-1:0] modulus,
                                                         input logic [DATA_W-1:0] exponent);
        logic [63:0] mask;
        logic [63:0] m;
        logic [63:0] e;
        logic [63:0] b;
        logic [63:0] acc;
        int          i;
        mask = (64'd1 << W) - 64'd1;
        m    = 64'(modulus) & mask;
        e    = 64'(exponent) & mask;
        b    = mod_reduce(64'(base) & mask, m);
        // running result starts at 1 and is only reduced on a set bit
        acc  = 64'd1;
        for (i = 0; i < W; i++)
        begin
            if (e[i])
                acc = mod_reduce(acc * b, m);
            b = mod_reduce(b * b, m);
        end
        return acc[DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------

    // setup then access; the bus then rests idle before the task returns so psel never
    // drops and rises in the same step
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] got;
        apb_read(addr, got);
        if (got !== want)
        begin
            $display("%0t: register 0x%0h readback mismatch: expected %h, actual %h",
                     $time, addr, want, got);
            mismatch_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // lowers valid and waits until every predicted result has come back,
    // which also leaves the sequencer idle
    task automatic wait_drained();
        base_ch.valid <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge clk);
    endtask

    // registers only change with the core idle
    task automatic set_config(input logic [DATA_W-1:0] modulus, input logic [DATA_W-1:0] exponent);
        wait_drained();
        modulus_shadow  = modulus;
        exponent_shadow = exponent;
        apb_write(ADDR_MODULUS, modulus);
        apb_write(ADDR_EXPONENT, exponent);
        check_register(ADDR_MODULUS, modulus_shadow);
        check_register(ADDR_EXPONENT, exponent_shadow);
    endtask

    // valid stays high from one request to the next unless an idle gap is drawn
    task automatic send_base(input logic [DATA_W-1:0] base);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            base_ch.valid      <= 1'b0;
            base_ch.base_value <= $urandom;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        base_ch.valid      <= 1'b1;
        base_ch.base_value <= base;
        do @(posedge clk); while (!base_ch.ready);
        pending_powers.push_back(expected_power(base, modulus_shadow, exponent_shadow));
    endtask

    // ------------------------------------------------------------------
    // random picks
    // ------------------------------------------------------------------

    // moduli 0 and 1 take the short path, so they come up often
    function automatic logic [DATA_W-1:0] pick_modulus();
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return 32'd1;
            3:       return '1;
            4:       return $urandom_range(255, 2);
            5:       return 32'h8000_0000 | $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_exponent();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1;
            3:       return 32'd1 << $urandom_range(W - 1);
            default: return $urandom;
        endcase
    endfunction

    // bases around the modulus exercise the initial reduction
    function automatic logic [DATA_W-1:0] pick_base(input logic [DATA_W-1:0] modulus);
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return modulus - 32'd1;
            3:       return modulus;
            4:       return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // registers come out of reset as modulus 1, exponent 0, so any base gives 1
    task automatic test_reset_values();
        check_register(ADDR_MODULUS, MODULUS_RST);
        check_register(ADDR_EXPONENT, EXPONENT_RST);
        send_base('0);
        send_base('1);
        wait_drained();
    endtask

    // zero and one moduli: exponent zero still gives 1, otherwise 0
    task automatic test_degenerate_modulus();
        set_config('0, '0);
        send_base(32'd123);
        set_config('0, 32'd7);
        send_base(32'd5);
        set_config(32'd1, '1);
        send_base('1);
        set_config(32'd1, '0);
        send_base(32'd77);
        wait_drained();
    endtask

    // all-ones modulus and exponent, with bases at and around the edges
    task automatic test_full_width();
        set_config('1, '1);
        send_base('0);
        send_base(32'd1);
        send_base(32'hFFFF_FFFE);
        send_base('1);
        send_base(32'h8000_0000);
        wait_drained();
    endtask

    // largest 32-bit prime with exponent p-1 gives 1 for any base not a multiple;
    // plus a parity modulus and an exponent with only the top bit set
    task automatic test_known_values();
        set_config(32'hFFFF_FFFB, 32'hFFFF_FFFA);
        send_base(32'd2);
        send_base(32'd12345);
        send_base('1);
        set_config(32'd2, 32'd1);
        send_base(32'd3);
        send_base(32'hFFFF_FFFE);
        set_config(32'd1000003, 32'h8000_0000);
        send_base(32'hDEAD_BEEF);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering, so the core fills
    // and stalls its input; then the sender pauses until all results are back
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        set_config(32'h8000_0000 | $urandom, $urandom);
        rx_hold_req = HOLD_CYCLES;
        repeat (6)
            send_base($urandom);
        wait_drained();
        repeat (2)
            send_base($urandom);
        wait_drained();
    endtask

    // several random settings, each drained before the next is written
    task automatic test_random_phase(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (CFGS_PER_PHASE)
        begin
            set_config(pick_modulus(), pick_exponent());
            repeat (ITEMS_PER_CFG)
                send_base(pick_base(modulus_shadow));
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver: random stalls, or a long hold-off counted here when asked
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (rx_hold_req) @(posedge clk);
                rx_hold_req = 0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        logic [DATA_W-1:0] want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_powers.size() == 0)
            begin
                $display("%0t: unexpected power_result: expected none, actual %h",
                         $time, result_ch.power_result);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_powers.pop_front();
                if (result_ch.power_result !== want)
                begin
                    $display("%0t: power_result mismatch: expected %h, actual %h",
                             $time, want, result_ch.power_result);
                    mismatch_cnt++;
                end
            end
        end
    end

    // watchdog on stretches with no request moving either way
    always @(posedge clk)
    begin
        if ((base_ch.valid && base_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles < WATCHDOG_MAX)
            quiet_cycles <= quiet_cycles + 1;
        else
        begin
            $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_MAX);
            $display("** modular_exponentiation_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        base_ch.valid      = 1'b0;
        base_ch.base_value = '0;
        modulus_shadow     = MODULUS_RST;
        exponent_shadow    = EXPONENT_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_degenerate_modulus();
        test_full_width();
        test_known_values();
        test_output_backpressure();
        // idle mixes: none, sender only, receiver only, both
        test_random_phase(0, 0);
        test_random_phase(57, 0);
        test_random_phase(0, 57);
        test_random_phase(24, 24);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("** modular_exponentiation_core: PASSED **");
        else
            $display("** modular_exponentiation_core: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
design/mxp_pkg.sv
design/mxp_base_if.sv
design/mxp_result_if.sv
design/mxp_modmul.sv
design/modular_exponentiation_core.sv
verif/tb_top.sv
